// ===== sv/lbaa_pkg.sv =====
package lbaa_pkg;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_ADJUST_ENABLE    = 3'd0;
   localparam logic [2:0] CSR_WINDOW_FRAMES    = 3'd1;
   localparam logic [2:0] CSR_GOAL_GRAY        = 3'd2;
   localparam logic [2:0] CSR_SAFE_DEVIATION   = 3'd3;
   localparam logic [2:0] CSR_UPPER_BRIGHTNESS = 3'd4;
   localparam logic [2:0] CSR_LOWER_BRIGHTNESS = 3'd5;
   localparam logic [2:0] CSR_CHANNEL_COUNT    = 3'd6;

   // Brightness limits for a change and the step sizes.
   localparam logic [7:0] BRIGHT_FLOOR = 8'd50;
   localparam logic [7:0] BRIGHT_CEIL  = 8'd255;
   localparam logic [3:0] WIDE_MARGIN  = 4'd10;
   localparam logic [3:0] SMALL_STEP   = 4'd5;
   localparam logic [3:0] LARGE_STEP   = 4'd10;

   // Result codes.
   typedef enum logic [1:0] {
      ACT_HOLD     = 2'd0,
      ACT_DIM      = 2'd1,
      ACT_BRIGHTEN = 2'd2,
      ACT_BLOCKED  = 2'd3
   } action_type;

   // Configuration register file.
   typedef struct packed {
      logic       adjust_enable;
      logic [7:0] window_frames;
      logic [7:0] goal_gray;
      logic [7:0] safe_deviation;
      logic [7:0] upper_brightness;
      logic [7:0] lower_brightness;
      logic [1:0] channel_count;
   } cfg_type;

   // One entry of the window store.
   typedef struct packed {
      logic [15:0] sum;
      logic [7:0]  count;
   } win_type;

   // A window that is due for a decision, with its precomputed thresholds.
   typedef struct packed {
      logic               channel;
      logic [7:0]         brightness;
      logic               can_change;
      logic [15:0]        sum;
      logic [16:0]        thr_high;
      logic signed [17:0] thr_low;
      logic [11:0]        margin;
   } eval_type;

endpackage

// ===== sv/lbaa_window_ram.sv =====
module lbaa_window_ram
   import lbaa_pkg::*;
#(
   parameter int DEPTH = 2,
   parameter int IDX_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_idx,
   output win_type          rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  win_type          wr_data
);

   win_type            mem [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   win_type            rd_data_ff;

   // An entry that was never written since reset reads as an empty window.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // Registered read; a write to the same entry in the same cycle is not seen.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_idx] ? mem[rd_idx] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lbaa_decide.sv =====
module lbaa_decide
   import lbaa_pkg::*;
(
   input  eval_type   ev,
   input  cfg_type    cfg,
   output action_type action,
   output logic [7:0] new_brightness
);

   logic signed [18:0] sum_s;
   logic signed [18:0] high_s;
   logic signed [18:0] high_far_s;
   logic signed [18:0] low_s;
   logic signed [18:0] low_far_s;
   logic signed [18:0] margin_s;
   logic               above;
   logic               far_above;
   logic               below;
   logic               far_below;
   logic [8:0]         dim_v;
   logic [8:0]         bright_v;
   logic [8:0]         step_dn;
   logic [8:0]         step_up;

   // Window sum against the four thresholds, all in signed arithmetic.
   always_comb begin
      sum_s      = $signed({3'b000, ev.sum});
      high_s     = $signed({2'b00, ev.thr_high});
      margin_s   = $signed({7'b0000000, ev.margin});
      high_far_s = high_s + margin_s;
      low_s      = 19'(ev.thr_low);
      low_far_s  = low_s - margin_s;
      above      = sum_s > high_s;
      far_above  = sum_s > high_far_s;
      below      = sum_s < low_s;
      far_below  = sum_s < low_far_s;
   end

   // Step and clamp.
   always_comb begin
      step_dn  = far_above ? 9'(LARGE_STEP) : 9'(SMALL_STEP);
      step_up  = far_below ? 9'(LARGE_STEP) : 9'(SMALL_STEP);
      dim_v    = {1'b0, ev.brightness} - step_dn;
      bright_v = {1'b0, ev.brightness} + step_up;
      action         = ACT_HOLD;
      new_brightness = ev.brightness;
      if (above) begin
         if (ev.can_change) begin
            action         = ACT_DIM;
            new_brightness = (dim_v > {1'b0, cfg.lower_brightness}) ?
                             dim_v[7:0] : cfg.lower_brightness;
         end else begin
            action = ACT_BLOCKED;
         end
      end else if (below) begin
         if (ev.can_change) begin
            action         = ACT_BRIGHTEN;
            new_brightness = (bright_v < {1'b0, cfg.upper_brightness}) ?
                             bright_v[7:0] : cfg.upper_brightness;
         end else begin
            action = ACT_BLOCKED;
         end
      end
   end

endmodule

// ===== sv/light_brightness_auto_adjust.sv =====
// A result passes through the accept stage, the decision stage and the output register.
// Throughput: one request per cycle while req_stall is low; the window store is read at acceptance and
// written back when the accept stage moves on, with forwarding between back-to-back requests.
// Requests keep flowing while a result waits, until the two stages behind fill up.
// Reset (synchronous, active high) restores the register defaults, empties all
// windows through per-entry valid bits and clears the pipeline; no clearing pass.
module light_brightness_auto_adjust
   import lbaa_pkg::*;
#(
   parameter int CHANNELS = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_gray_value,
   input  logic       req_channel,
   input  logic [7:0] req_current_brightness,
   input  logic       req_brightness_ok,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_out_channel,
   output logic [1:0] rsp_action,
   output logic [7:0] rsp_new_brightness,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   cfg_type          cfg_ff;
   logic             s1_valid_ff;
   logic [7:0]       s1_gray_ff;
   logic             s1_channel_ff;
   logic [7:0]       s1_bright_ff;
   logic             s1_ok_ff;
   logic             fwd_ff;
   win_type          fwd_data_ff;
   logic             s2_valid_ff;
   eval_type         s2_ff;
   eval_type         s2_in;
   logic             rsp_valid_ff;
   logic             rsp_channel_ff;
   action_type       rsp_action_ff;
   logic [7:0]       rsp_bright_ff;

   logic             out_free;
   logic             s2_go;
   logic             s1_go;
   logic             accept;
   logic             load;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] wr_idx;
   win_type          rd_data;
   win_type          base;
   win_type          wr_data;
   logic             wr_en;
   logic [15:0]      sum_new;
   logic [7:0]       cnt_new;
   logic             due;
   logic [8:0]       dev_high;
   logic signed [9:0]  dev_low;
   logic signed [17:0] dev_low_ext;
   logic signed [17:0] cnt_s;
   action_type       dec_action;
   logic [7:0]       dec_bright;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.adjust_enable    <= 1'b0;
         cfg_ff.window_frames    <= 8'd3;
         cfg_ff.goal_gray        <= 8'd90;
         cfg_ff.safe_deviation   <= 8'd5;
         cfg_ff.upper_brightness <= 8'd200;
         cfg_ff.lower_brightness <= 8'd100;
         cfg_ff.channel_count    <= 2'd2;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ADJUST_ENABLE:    cfg_ff.adjust_enable    <= csr_wdata[0];
            CSR_WINDOW_FRAMES:    cfg_ff.window_frames    <= csr_wdata;
            CSR_GOAL_GRAY:        cfg_ff.goal_gray        <= csr_wdata;
            CSR_SAFE_DEVIATION:   cfg_ff.safe_deviation   <= csr_wdata;
            CSR_UPPER_BRIGHTNESS: cfg_ff.upper_brightness <= csr_wdata;
            CSR_LOWER_BRIGHTNESS: cfg_ff.lower_brightness <= csr_wdata;
            CSR_CHANNEL_COUNT:    cfg_ff.channel_count    <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Flow control: each stage moves when the one behind it is empty or moving.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_go     = !s2_valid_ff || out_free;
   assign s1_go     = !s1_valid_ff || s2_go;
   assign req_stall = !s1_go;
   assign accept    = req_valid && !req_stall;
   assign load      = accept && cfg_ff.adjust_enable && (32'(req_channel) < CHANNELS);

   assign rd_idx = IDX_W'(req_channel);
   assign wr_idx = IDX_W'(s1_channel_ff);
   assign wr_en  = s1_valid_ff && s2_go;

   lbaa_window_ram #(
      .DEPTH (CHANNELS),
      .IDX_W (IDX_W)
   ) u_window_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (load),
      .rd_idx  (rd_idx),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data)
   );

   // Accept stage; catch a write-back to the same channel in the same cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (s1_go) begin
         s1_valid_ff <= load;
         fwd_ff      <= wr_en && (wr_idx == rd_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_gray_ff    <= req_gray_value;
         s1_channel_ff <= req_channel;
         s1_bright_ff  <= req_current_brightness;
         s1_ok_ff      <= req_brightness_ok;
         fwd_data_ff   <= wr_data;
      end
   end

   // Accumulate the sample and decide whether the window is complete.
   always_comb begin
      base    = fwd_ff ? fwd_data_ff : rd_data;
      sum_new = base.sum + {8'h00, s1_gray_ff};
      cnt_new = base.count + 8'd1;
      due     = !(cnt_new < cfg_ff.window_frames);
      if (due) begin
         wr_data = '0;
      end else begin
         wr_data.sum   = sum_new;
         wr_data.count = cnt_new;
      end
   end

   // Thresholds scaled by the sample count.
   always_comb begin
      dev_high    = {1'b0, cfg_ff.goal_gray} + {1'b0, cfg_ff.safe_deviation};
      dev_low     = $signed({2'b00, cfg_ff.goal_gray}) - $signed({2'b00, cfg_ff.safe_deviation});
      dev_low_ext = 18'(dev_low);
      cnt_s       = $signed({10'b0, cnt_new});
      s2_in.channel    = s1_channel_ff;
      s2_in.brightness = s1_bright_ff;
      s2_in.can_change = s1_ok_ff
                         && ({1'b0, s1_channel_ff} < cfg_ff.channel_count)
                         && (s1_bright_ff > BRIGHT_FLOOR)
                         && (s1_bright_ff != BRIGHT_CEIL);
      s2_in.sum        = sum_new;
      s2_in.thr_high   = 17'(dev_high) * 17'(cnt_new);
      s2_in.thr_low    = dev_low_ext * cnt_s;
      s2_in.margin     = 12'(cnt_new) * 12'(WIDE_MARGIN);
   end

   // Decision stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_go) begin
         s2_valid_ff <= s1_valid_ff && due;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go && s1_valid_ff && due) begin
         s2_ff <= s2_in;
      end
   end

   lbaa_decide u_decide (
      .ev             (s2_ff),
      .cfg            (cfg_ff),
      .action         (dec_action),
      .new_brightness (dec_bright)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s2_valid_ff) begin
         rsp_channel_ff <= s2_ff.channel;
         rsp_action_ff  <= dec_action;
         rsp_bright_ff  <= dec_bright;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_channel    = rsp_channel_ff;
   assign rsp_action         = rsp_action_ff;
   assign rsp_new_brightness = rsp_bright_ff;

endmodule
